/* hdl/lpht_pkg.sv */
package lpht_pkg;

   // the table size must be a power of two: the probe start is the low hash bits
   localparam int TABLE_SIZE = 1024;
   localparam int KEY_W      = 64;
   localparam int VAL_W      = 64;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
   localparam int CFG_W  = 11;
   localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CFG_W-1:0]  MAX_ENTRIES_RST = CFG_W'(768);

   // request modes
   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_GET   = 2'd1;
   localparam logic [1:0] MODE_ERASE = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } slot_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

/* hdl/linear_probe_hash_table.sv */
// Channel   Direction  Handshake                 Content
// req_      in         req_tvalid / req_tready   tuser: mode; tdata: key, hash, value
// rsp_      out        rsp_tvalid / rsp_tready   tdata: status, value_out, entry_count_out
// csr_      in         csr_wr_en                 max_entries
//
// A probe starts the first slot read, then checks each slot through the single read port of
// the table memory while the next one is read (at most TABLE_SIZE - 1 slots), has a closing
// step when the range runs out and then loads the response. Insert threshold refusals,
// empty-map cases and unused modes go from acceptance straight to the response load,
// without a probe. After reset the table is swept once to mark every slot empty, with
// req_tready low throughout. One request is in flight at a time; req_tready returns the
// cycle after the response is loaded, and a response still waiting for rsp_tready holds
// the next request in its last step.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // key[63:0], hash[95:64], value[159:96]
   input  logic [1:0]   req_tuser,   // mode[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // status[1:0], value_out[65:2],
                                     // entry_count_out[76:66], zero[79:77]
   input  logic         csr_wr_en,
   input  logic [10:0]  csr_wr_data
);

   slot_type mem [TABLE_SIZE];

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [CFG_W-1:0]  max_ff, max_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  issue_ptr_ff, issue_ptr_in;
   logic [IDX_W-1:0]  stop_ff, stop_in;
   logic              issue_end_ff, issue_end_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_ptr_ff, chk_ptr_in;
   logic              erased_ff, erased_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [1:0]        mode_ff, mode_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [VAL_W-1:0]  res_value_ff, res_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [63:0]       rsp_value_ff, rsp_value_in;
   logic [CFG_W-1:0]  rsp_count_ff, rsp_count_in;

   slot_type          rd_data_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_type          wr_data;

   logic              req_acc;
   logic [IDX_W-1:0]  start_slot;
   logic [IDX_W-1:0]  issue_nxt;
   logic              hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff, rsp_status_ff};

   // hash mod table size: the low hash bits
   assign start_slot = req_tdata[64 +: IDX_W];

   assign issue_nxt = (issue_ptr_ff == LAST_IDX) ? '0 : (issue_ptr_ff + 1'b1);
   assign hit       = rd_data_ff.used && (rd_data_ff.key == key_ff);

   always_comb begin
      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      max_in        = max_ff;
      count_in      = count_ff;
      issue_ptr_in  = issue_ptr_ff;
      stop_in       = stop_ff;
      issue_end_in  = issue_end_ff;
      chk_vld_in    = 1'b0;
      chk_ptr_in    = chk_ptr_ff;
      erased_in     = erased_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_ptr_ff;
      wr_data       = '0;

      if (csr_wr_en) begin
         max_in = csr_wr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               mode_in       = req_tuser;
               key_in        = req_tdata[KEY_W-1:0];
               val_in        = req_tdata[96 +: VAL_W];
               issue_ptr_in  = start_slot;
               stop_in       = (start_slot == '0) ? LAST_IDX : (start_slot - 1'b1);
               issue_end_in  = 1'b0;
               erased_in     = 1'b0;
               res_status_in = STAT_DONE;
               res_value_in  = '0;
               state_in      = ST_DONE;
               case (req_tuser)
                  MODE_SET: begin
                     if (CMP_W'(count_ff) + 1'b1 > CMP_W'(max_ff)) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  MODE_GET, MODE_ERASE: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                     res_status_in = STAT_DONE;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            // issue the next slot read while checking the previous one
            if (!issue_end_ff) begin
               chk_vld_in   = 1'b1;
               chk_ptr_in   = issue_ptr_ff;
               issue_ptr_in = issue_nxt;
               issue_end_in = (issue_nxt == stop_ff);
            end
            if (chk_vld_ff) begin
               case (mode_ff)
                  MODE_SET: begin
                     if (!rd_data_ff.used || hit) begin
                        wr_en   = 1'b1;
                        wr_data = '{used: 1'b1, key: key_ff, value: val_ff};
                        if (!hit) begin
                           count_in = count_ff + 1'b1;
                        end
                        res_status_in = STAT_DONE;
                        state_in      = ST_DONE;
                     end
                  end
                  MODE_GET: begin
                     if (hit) begin
                        res_status_in = STAT_DONE;
                        res_value_in  = rd_data_ff.value;
                        state_in      = ST_DONE;
                     end
                  end
                  default: begin
                     if (hit) begin
                        wr_en     = 1'b1;
                        wr_data   = '0;
                        count_in  = count_ff - 1'b1;
                        erased_in = 1'b1;
                     end
                  end
               endcase
            end else if (issue_end_ff) begin
               // probe range exhausted
               state_in = ST_DONE;
               case (mode_ff)
                  MODE_SET:   res_status_in = STAT_FULL;
                  MODE_GET:   res_status_in = STAT_NOT_FOUND;
                  default:    res_status_in = erased_ff ? STAT_DONE : STAT_NOT_FOUND;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = 64'(res_value_ff);
               rsp_count_in  = CFG_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         max_ff       <= MAX_ENTRIES_RST;
         count_ff     <= '0;
         issue_end_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         erased_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         issue_end_ff <= issue_end_in;
         chk_vld_ff   <= chk_vld_in;
         erased_ff    <= erased_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ptr_ff  <= issue_ptr_in;
      stop_ff       <= stop_in;
      chk_ptr_ff    <= chk_ptr_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[issue_ptr_ff];
   end

endmodule
